FILE: design/mwprt_pkg.sv
// Shared types and constants for the motion-wake power and race timer block.
package mwprt_pkg;

  // Input kind codes (tuser)
  localparam logic [1:0] KIND_SHAKE  = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_PACKET = 2'd2;

  // Packet tag bytes
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_S = 8'h53;

  // Configuration register indexes
  localparam logic [1:0] CFG_SHAKE_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_SHAKE_WINDOW    = 2'd1;
  localparam logic [1:0] CFG_IDLE_TIMEOUT    = 2'd2;
  localparam logic [1:0] CFG_RACE_LIMIT      = 2'd3;

  // Configuration reset values
  localparam logic [5:0]  RST_SHAKE_THRESHOLD = 6'd40;
  localparam logic [7:0]  RST_SHAKE_WINDOW    = 8'd5;
  localparam logic [11:0] RST_IDLE_TIMEOUT    = 12'd600;
  localparam logic [11:0] RST_RACE_LIMIT      = 12'd300;

  // Encoded power mode on the result
  localparam logic [1:0] PM_SLEEP  = 2'd0;
  localparam logic [1:0] PM_DROWSE = 2'd1;
  localparam logic [1:0] PM_WAKE   = 2'd2;

  // Millisecond arithmetic
  localparam logic [10:0] MS_PER_SEC  = 11'd1000;
  localparam logic [16:0] DIV1000_MUL = 17'd67109;  // ceil(2^26 / 1000)
  localparam logic [15:0] RTC_FULL    = 16'd32768;
  localparam logic [15:0] STOP_MAX    = 16'hFFFF;

  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    EV_NONE,     // nothing to do (unused kind)
    EV_SHAKE,
    EV_TICK,
    EV_PKT,      // packet without a start or stop action
    EV_START,
    EV_STOP
  } event_t;

  typedef enum logic [2:0] {
    MODE_SLEEP  = 3'b001,
    MODE_DROWSE = 3'b010,
    MODE_WAKE   = 3'b100
  } mode_t;

  // Classified event, front to back
  typedef struct packed {
    event_t      ev;
    logic [6:0]  offset_secs;
    logic [9:0]  offset_ms;
    logic [9:0]  frac_ms;
  } cmd_t;

  typedef struct packed {
    logic [15:0] stops_last_second;
    logic [9:0]  race_millis;
    logic [12:0] race_seconds;
    logic        race_finished;
    logic        race_running;
    logic [1:0]  power_mode;
  } result_t;

endpackage

FILE: design/mwprt_front.sv
// Front end: accepts input beats, classifies them and precomputes the ms arithmetic.
module mwprt_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_kind,
  input  logic [7:0]               in_tag_first,
  input  logic [7:0]               in_tag_second,
  input  logic [7:0]               in_value_high,
  input  logic [7:0]               in_value_low,
  input  logic [14:0]              in_rtc_divider,
  output logic                     push,
  output mwprt_pkg::cmd_t          push_cmd,
  input  logic                     q_full
);
  import mwprt_pkg::*;

  logic        stg_valid;
  event_t      stg_ev;
  logic [15:0] stg_offset;
  logic [6:0]  stg_q;
  logic [9:0]  stg_frac;

  logic        accept;
  event_t      ev_dec;
  logic [15:0] offset;
  logic [32:0] q_prod;
  logic [15:0] rtc_left;
  logic [25:0] frac_prod;
  logic [16:0] q_times;
  logic [16:0] rem_full;

  assign in_ready = !stg_valid || !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = stg_valid && !q_full;

  always_comb begin
    priority if (in_kind == KIND_SHAKE) begin
      ev_dec = EV_SHAKE;
    end else if (in_kind == KIND_TICK) begin
      ev_dec = EV_TICK;
    end else if (in_kind == KIND_PACKET) begin
      if (in_tag_first == CH_T && in_tag_second == CH_R) ev_dec = EV_START;
      else if (in_tag_first == CH_T && in_tag_second == CH_S) ev_dec = EV_STOP;
      else ev_dec = EV_PKT;
    end else begin
      ev_dec = EV_NONE;
    end
  end

  // offset / 1000 by reciprocal, exact for 16-bit offsets
  assign offset    = {in_value_high, in_value_low};
  assign q_prod    = 33'(offset) * 33'(DIV1000_MUL);
  // (32768 - div) * 1000 / 32768, range 0..1000
  assign rtc_left  = RTC_FULL - {1'b0, in_rtc_divider};
  assign frac_prod = 26'(rtc_left) * 26'(MS_PER_SEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (push) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_ev     <= ev_dec;
      stg_offset <= offset;
      stg_q      <= q_prod[32:26];
      stg_frac   <= frac_prod[24:15];
    end
  end

  // remainder after the registered quotient
  assign q_times  = 17'(stg_q) * 17'(MS_PER_SEC);
  assign rem_full = {1'b0, stg_offset} - q_times;

  always_comb begin
    push_cmd.ev          = stg_ev;
    push_cmd.offset_secs = stg_q;
    push_cmd.offset_ms   = rem_full[9:0];
    push_cmd.frac_ms     = stg_frac;
  end

endmodule

FILE: design/mwprt_queue.sv
// Small register queue between the front and back ends.
module mwprt_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mwprt_pkg::cmd_t  push_cmd,
  output logic             full,
  input  logic             pop,
  output mwprt_pkg::cmd_t  head,
  output logic             empty
);
  import mwprt_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: design/mwprt_back.sv
// Back end: power mode and race timer state, config registers and result register.
module mwprt_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [1:0]                         cfg_index,
  input  logic [mwprt_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               q_empty,
  input  mwprt_pkg::cmd_t                    head,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output mwprt_pkg::result_t                 out_res
);
  import mwprt_pkg::*;

  // configuration
  logic [5:0]  shake_threshold;
  logic [7:0]  shake_window;
  logic [11:0] idle_timeout;
  logic [11:0] race_limit;

  // state
  mode_t       mode;
  logic [5:0]  shake_count;
  logic [7:0]  drowse_seconds;
  logic [11:0] idle_seconds;
  logic        running;
  logic        finished;
  logic [12:0] race_secs;
  logic [9:0]  start_millis;
  logic [9:0]  fraction_millis;
  logic [15:0] stop_count;
  logic [15:0] stop_snapshot;

  mode_t       mode_next;
  logic [5:0]  shake_count_next;
  logic [7:0]  drowse_seconds_next;
  logic [11:0] idle_seconds_next;
  logic        running_next;
  logic        finished_next;
  logic [12:0] race_secs_next;
  logic [9:0]  start_millis_next;
  logic [9:0]  fraction_millis_next;
  logic [15:0] stop_count_next;
  logic [15:0] stop_snapshot_next;
  logic [10:0] frac_sum;
  logic [1:0]  pm_code;

  assign pop = !q_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      shake_threshold <= RST_SHAKE_THRESHOLD;
      shake_window    <= RST_SHAKE_WINDOW;
      idle_timeout    <= RST_IDLE_TIMEOUT;
      race_limit      <= RST_RACE_LIMIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SHAKE_THRESHOLD: shake_threshold <= cfg_data[5:0];
        CFG_SHAKE_WINDOW:    shake_window    <= cfg_data[7:0];
        CFG_IDLE_TIMEOUT:    idle_timeout    <= cfg_data[11:0];
        CFG_RACE_LIMIT:      race_limit      <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_next            = mode;
    shake_count_next     = shake_count;
    drowse_seconds_next  = drowse_seconds;
    idle_seconds_next    = idle_seconds;
    running_next         = running;
    finished_next        = finished;
    race_secs_next       = race_secs;
    start_millis_next    = start_millis;
    fraction_millis_next = fraction_millis;
    stop_count_next      = stop_count;
    stop_snapshot_next   = stop_snapshot;
    frac_sum             = '0;

    unique case (head.ev)
      EV_SHAKE: begin
        if (shake_count < shake_threshold) shake_count_next = shake_count + 1'b1;
        if (mode == MODE_SLEEP) begin
          mode_next           = MODE_DROWSE;
          shake_count_next    = '0;
          drowse_seconds_next = '0;
        end else if (mode == MODE_WAKE) begin
          idle_seconds_next = idle_timeout;
        end
      end
      EV_TICK: begin
        if (mode != MODE_SLEEP) begin
          if (running) begin
            if (race_secs < {1'b0, race_limit}) begin
              race_secs_next = race_secs + 1'b1;
            end else begin
              running_next      = 1'b0;
              idle_seconds_next = idle_timeout;
            end
          end
          stop_snapshot_next = stop_count;
          stop_count_next    = '0;
          if (mode == MODE_WAKE) begin
            // idle countdown only while no race is running after this tick
            if (!running_next) begin
              if (idle_seconds_next != '0) idle_seconds_next = idle_seconds_next - 1'b1;
              else mode_next = MODE_SLEEP;
            end
          end else begin
            if (drowse_seconds != 8'hFF) drowse_seconds_next = drowse_seconds + 1'b1;
            if (drowse_seconds_next >= shake_window) begin
              if (shake_count >= shake_threshold) begin
                mode_next         = MODE_WAKE;
                idle_seconds_next = idle_timeout;
              end else begin
                mode_next = MODE_SLEEP;
              end
              shake_count_next = '0;
            end
          end
        end
      end
      EV_PKT, EV_START, EV_STOP: begin
        if (mode == MODE_WAKE) begin
          if (running) fraction_millis_next = head.frac_ms;
          if (head.ev == EV_START && !running) begin
            idle_seconds_next = idle_timeout;
            race_secs_next    = {6'd0, head.offset_secs};
            start_millis_next = head.offset_ms;
            running_next      = 1'b1;
            finished_next     = 1'b0;
          end else if (head.ev == EV_STOP) begin
            running_next      = 1'b0;
            idle_seconds_next = idle_timeout;
            if (stop_count != STOP_MAX) stop_count_next = stop_count + 1'b1;
            if (!finished) begin
              finished_next = 1'b1;
              frac_sum = {1'b0, fraction_millis_next} + {1'b0, start_millis};
              if (frac_sum >= MS_PER_SEC) begin
                race_secs_next       = race_secs_next + 1'b1;
                fraction_millis_next = 10'(frac_sum - MS_PER_SEC);
              end else begin
                fraction_millis_next = frac_sum[9:0];
              end
            end
          end
        end
      end
      default: ;  // unused kind: state unchanged
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_WAKE;
      shake_count     <= '0;
      drowse_seconds  <= '0;
      idle_seconds    <= RST_IDLE_TIMEOUT;
      running         <= 1'b0;
      finished        <= 1'b0;
      race_secs       <= '0;
      start_millis    <= '0;
      fraction_millis <= '0;
      stop_count      <= '0;
      stop_snapshot   <= '0;
    end else if (pop) begin
      mode            <= mode_next;
      shake_count     <= shake_count_next;
      drowse_seconds  <= drowse_seconds_next;
      idle_seconds    <= idle_seconds_next;
      running         <= running_next;
      finished        <= finished_next;
      race_secs       <= race_secs_next;
      start_millis    <= start_millis_next;
      fraction_millis <= fraction_millis_next;
      stop_count      <= stop_count_next;
      stop_snapshot   <= stop_snapshot_next;
    end
  end

  always_comb begin
    unique case (mode_next)
      MODE_SLEEP:  pm_code = PM_SLEEP;
      MODE_DROWSE: pm_code = PM_DROWSE;
      MODE_WAKE:   pm_code = PM_WAKE;
      default:     pm_code = PM_WAKE;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res.power_mode        <= pm_code;
      out_res.race_running      <= running_next;
      out_res.race_finished     <= finished_next;
      out_res.race_seconds      <= race_secs_next;
      out_res.race_millis       <= fraction_millis_next;
      out_res.stops_last_second <= stop_snapshot_next;
    end
  end

endmodule

FILE: design/motion_wake_power_and_race_timer_core.sv
// Motion-wake power controller with race timer: top level.
//
// Input stream (s_*): one beat per event. s_tuser carries the event kind
// (shake, one-second tick, packet); s_tdata carries the four packet bytes and
// the RTC prescaler divider latched at packet arrival.
// Output stream (m_*): exactly one result beat per input beat, in order, with
// the power mode and race timer state after that event.
// Config channel (cfg_*): writes one of four registers by index; always ready.
// Write only while no event is in flight.
//
// Path from input beat to result valid: classify stage, queue, state update
// into the result register.
// Throughput: one beat per cycle while m_tready is high; the state update in
// the back end is done in one step, so a beat can follow every cycle.
// Front and back are split by a QUEUE_DEPTH-entry queue. When m_tready is low
// the result register holds, the back end stops popping, the queue fills and
// s_tready drops once the classify stage cannot drain.
// Reset (rst, synchronous): mode wake, idle count 600, race cleared, config at
// defaults, queue and output empty.
module motion_wake_power_and_race_timer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // tag_first[7:0], tag_second[15:8], value_high[23:16], value_low[31:24],
  // rtc_divider[46:32], zero[47]
  input  logic [mwprt_pkg::IN_DATA_W-1:0]      s_tdata,
  // kind[1:0]
  input  logic [1:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // power_mode[1:0], race_running[2], race_finished[3], race_seconds[16:4],
  // race_millis[26:17], stops_last_second[42:27], zero[47:43]
  output logic [mwprt_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [mwprt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mwprt_pkg::*;

  logic    push;
  cmd_t    push_cmd;
  logic    q_full;
  logic    q_empty;
  logic    pop;
  cmd_t    head;
  result_t res;

  assign cfg_ready = 1'b1;

  mwprt_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_kind        (s_tuser),
    .in_tag_first   (s_tdata[7:0]),
    .in_tag_second  (s_tdata[15:8]),
    .in_value_high  (s_tdata[23:16]),
    .in_value_low   (s_tdata[31:24]),
    .in_rtc_divider (s_tdata[46:32]),
    .push           (push),
    .push_cmd       (push_cmd),
    .q_full         (q_full)
  );

  mwprt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  mwprt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {5'd0, res};

endmodule

FILE: design/mwprt_checker.sv
// Port-level checker for the motion-wake power and race timer block, with bind.
module mwprt_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [mwprt_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import mwprt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'b11)
    else $error("power mode code out of range");

  a_run_fin: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
    else $error("race both running and finished");

endmodule

bind motion_wake_power_and_race_timer_core mwprt_checker u_mwprt_checker (.*);
